// ===== hdl/conv2d_valid_multichannel_defines.svh =====
// Assertion macros shared by the convolution block.
`ifndef CONV2D_VALID_MULTICHANNEL_DEFINES_SVH
`define CONV2D_VALID_MULTICHANNEL_DEFINES_SVH
`ifndef SYNTH
`define CV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CV_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define CV_ASSERT(lbl, clk, rst, prop, msg)
`define CV_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== hdl/cnv2d_pkg.sv =====
// Shared constants, command and status types for the convolution block.
`timescale 1ns / 1ps
`default_nettype none
package cnv2d_pkg;
   localparam int IN_CHANNELS_DEF  = 4;
   localparam int OUT_CHANNELS_DEF = 16;
   localparam int MAX_KERNEL_DEF   = 7;
   localparam int MAX_WIDTH_DEF    = 32;
   localparam int MAX_HEIGHT_DEF   = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;
   localparam int PIX_W      = 16;
   localparam int WT_W       = 16;
   localparam int SUM_W      = 40;

   localparam logic [CSR_IDX_W-1:0] REG_IN_CH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd4;

   localparam logic ACTION_WEIGHT = 1'b0;
   localparam logic ACTION_PIXEL  = 1'b1;

   typedef struct packed {
      logic wt_write;
      logic px_write;
      logic oc_init;
      logic k_init;
      logic issue;
      logic psum_rd;
      logic psum_wr;
      logic oc_next;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic win;
      logic last_ch;
      logic k_last;
      logic oc_last;
      logic busy;
      logic out_free;
   } status_type;

   // zero maps to one, anything above hi maps to hi
   function automatic logic [CSR_DATA_W-1:0] clamp_field(logic [CSR_DATA_W-1:0] v, int hi);
      logic [CSR_DATA_W-1:0] r;
      r = v;
      if (v == '0) r = CSR_DATA_W'(1);
      else if (int'(v) > hi) r = CSR_DATA_W'(hi);
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/cnv2d_ctrl.sv =====
// Sequencer for the convolution block: walks each window over the output channels.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_valid_multichannel_defines.svh"
module cnv2d_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_action,
   output logic                       req_stall,
   output cnv2d_pkg::cmd_type         cmd,
   input  wire cnv2d_pkg::status_type status
);
   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_KINIT, S_ISSUE, S_DRAIN, S_PSRD, S_PSWR
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == cnv2d_pkg::ACTION_PIXEL) begin
                  cmd.px_write = 1'b1;
                  state_in     = S_CHECK;
               end else begin
                  cmd.wt_write = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (status.win) begin
               cmd.oc_init = 1'b1;
               state_in    = S_KINIT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_KINIT: begin
            cmd.k_init = 1'b1;
            state_in   = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.k_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!status.busy) state_in = S_PSRD;
         end
         S_PSRD: begin
            cmd.psum_rd = 1'b1;
            state_in    = S_PSWR;
         end
         S_PSWR: begin
            // on the last channel the sum goes out, so wait for the output slot
            if (!status.last_ch || status.out_free) begin
               cmd.psum_wr = 1'b1;
               if (status.oc_last) begin
                  cmd.advance = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.oc_next = 1'b1;
                  state_in    = S_KINIT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `CV_ASSERT(a_emit_slot, clock, reset, !(cmd.psum_wr && status.last_ch) || status.out_free, "result emitted while output slot full")
   `CV_ASSERT(a_acc_settled, clock, reset, !cmd.psum_rd || !status.busy, "partial sum read before accumulator settled")
   `CV_ASSERT_NEXT(a_px_check, clock, reset, cmd.px_write, state_ff == S_CHECK, "pixel item not followed by window check")
endmodule
`default_nettype wire

// ===== hdl/cnv2d_dp.sv =====
// Datapath: configuration, counters, weight/row/partial-sum stores, MAC and output register.
`timescale 1ns / 1ps
`default_nettype none
module cnv2d_dp #(
   parameter int IN_CHANNELS  = cnv2d_pkg::IN_CHANNELS_DEF,
   parameter int OUT_CHANNELS = cnv2d_pkg::OUT_CHANNELS_DEF,
   parameter int MAX_KERNEL   = cnv2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH    = cnv2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = cnv2d_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_en,
   input  wire logic [cnv2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cnv2d_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic [11:0]                           req_weight_index,
   input  wire logic signed [cnv2d_pkg::WT_W-1:0]     req_weight_value,
   input  wire logic signed [cnv2d_pkg::PIX_W-1:0]    req_pixel_value,
   input  wire cnv2d_pkg::cmd_type                    cmd,
   output cnv2d_pkg::status_type                      status,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [3:0]                                 rsp_out_channel,
   output logic [4:0]                                 rsp_out_row,
   output logic [4:0]                                 rsp_out_col,
   output logic signed [cnv2d_pkg::SUM_W-1:0]         rsp_conv_sum,
   output logic                                       rsp_last,
   output logic                                       rsp_image_done
);
   localparam int WDEPTH  = OUT_CHANNELS * IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int WI_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int WA_W    = $clog2(WDEPTH + 1);
   localparam int PDEPTH  = OUT_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int PI_W    = $clog2(PDEPTH);
   localparam int RDEPTH  = MAX_KERNEL * MAX_WIDTH;
   localparam int RI_W    = $clog2(RDEPTH);
   localparam int CH_W    = $clog2(IN_CHANNELS + 1);
   localparam int OC_W    = $clog2(OUT_CHANNELS + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH + 1);
   localparam int KR_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int OUT_CAP = (OUT_CHANNELS > 16) ? 16 : OUT_CHANNELS;
   localparam int PROD_W  = cnv2d_pkg::PIX_W + cnv2d_pkg::WT_W;
   localparam int ACC_W   = PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int TOT_W   = cnv2d_pkg::SUM_W + 2;
   localparam logic signed [TOT_W-1:0] SMAX = (TOT_W'(1) <<< (cnv2d_pkg::SUM_W - 1)) - TOT_W'(1);
   localparam logic signed [TOT_W-1:0] SMIN = -(TOT_W'(1) <<< (cnv2d_pkg::SUM_W - 1));

   // configuration, stored already clamped
   logic [2:0] nin_ff;
   logic [4:0] nout_ff;
   logic [2:0] k_ff;
   logic [5:0] h_ff, w_ff;
   logic [WA_W-1:0] kk_ff, ninkk_ff;
   logic cfg_hit;

   // pixel position counters
   logic [CH_W-1:0]  c_ff, c_in;
   logic [ROW_W-1:0] r_ff, r_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [KR_W-1:0]  rmod_ff, rmod_in;

   // window walk
   logic [OC_W-1:0]  oc_ff;
   logic [WA_W-1:0]  base_ff, wa_ff;
   logic [2:0]       kr_ff, kc_ff;
   logic [KR_W-1:0]  rrow_ff, rrow_init;
   logic [COL_W-1:0] rcol_ff;

   logic [ROW_W-1:0] top;
   logic [COL_W-1:0] left;
   logic [PI_W-1:0]  pa;
   int               t_row;

   // stores
   logic signed [cnv2d_pkg::WT_W-1:0]  wmem [WDEPTH];
   logic signed [cnv2d_pkg::PIX_W-1:0] rbuf [RDEPTH];
   logic signed [cnv2d_pkg::SUM_W-1:0] pmem [PDEPTH];

   // MAC pipeline
   logic signed [cnv2d_pkg::WT_W-1:0]  wq_ff;
   logic                               wz_ff;
   logic signed [cnv2d_pkg::PIX_W-1:0] pq_ff;
   logic                               v1_ff, v2_ff;
   logic signed [PROD_W-1:0]           prod_ff;
   logic signed [ACC_W-1:0]            acc_ff;
   logic signed [cnv2d_pkg::SUM_W-1:0] psq_ff;
   logic signed [TOT_W-1:0]            tot;
   logic signed [cnv2d_pkg::SUM_W-1:0] sat;

   logic rsp_valid_ff;
   logic row_end, col_end;

   // only a write to a mapped register restarts the image
   assign cfg_hit = csr_write_en && (csr_index <= cnv2d_pkg::REG_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         nin_ff  <= 3'd1;
         nout_ff <= 5'd10;
         k_ff    <= 3'd5;
         h_ff    <= 6'd28;
         w_ff    <= 6'd28;
      end else if (csr_write_en) begin
         case (csr_index)
            cnv2d_pkg::REG_IN_CH:
               nin_ff <= 3'(cnv2d_pkg::clamp_field({3'b000, csr_data[2:0]}, IN_CHANNELS));
            cnv2d_pkg::REG_OUT_CH:
               nout_ff <= 5'(cnv2d_pkg::clamp_field({1'b0, csr_data[4:0]}, OUT_CAP));
            cnv2d_pkg::REG_KERNEL:
               k_ff <= 3'(cnv2d_pkg::clamp_field({3'b000, csr_data[2:0]}, MAX_KERNEL));
            cnv2d_pkg::REG_HEIGHT: h_ff <= cnv2d_pkg::clamp_field(csr_data, MAX_HEIGHT);
            cnv2d_pkg::REG_WIDTH:  w_ff <= cnv2d_pkg::clamp_field(csr_data, MAX_WIDTH);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kk_ff    <= WA_W'(int'(k_ff) * int'(k_ff));
      ninkk_ff <= WA_W'(int'(nin_ff) * int'(kk_ff));
   end

   assign top  = r_ff + ROW_W'(1) - ROW_W'(k_ff);
   assign left = col_ff + COL_W'(1) - COL_W'(k_ff);
   assign row_end = (int'(r_ff) + 1 >= int'(h_ff));
   assign col_end = (int'(col_ff) + 1 >= int'(w_ff));

   assign status.win      = (int'(r_ff) + 1 >= int'(k_ff)) && (int'(col_ff) + 1 >= int'(k_ff));
   assign status.last_ch  = (int'(c_ff) + 1 >= int'(nin_ff));
   assign status.k_last   = (int'(kr_ff) + 1 == int'(k_ff)) && (int'(kc_ff) + 1 == int'(k_ff));
   assign status.oc_last  = (int'(oc_ff) + 1 >= int'(nout_ff));
   assign status.busy     = v1_ff || v2_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      c_in    = c_ff;
      r_in    = r_ff;
      col_in  = col_ff;
      rmod_in = rmod_ff;
      if (cmd.advance) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               r_in    = '0;
               rmod_in = '0;
               c_in    = status.last_ch ? '0 : c_ff + CH_W'(1);
            end else begin
               r_in    = r_ff + ROW_W'(1);
               rmod_in = (int'(rmod_ff) + 1 >= MAX_KERNEL) ? '0 : rmod_ff + KR_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         c_ff    <= '0;
         r_ff    <= '0;
         col_ff  <= '0;
         rmod_ff <= '0;
      end else begin
         c_ff    <= c_in;
         r_ff    <= r_in;
         col_ff  <= col_in;
         rmod_ff <= rmod_in;
      end
   end

   // ring row of the window's top line
   always_comb begin
      t_row = int'(rmod_ff) + MAX_KERNEL - (int'(k_ff) - 1);
      if (t_row >= MAX_KERNEL) t_row = t_row - MAX_KERNEL;
      rrow_init = KR_W'(t_row);
   end

   always_ff @(posedge clock) begin
      if (cmd.oc_init) begin
         oc_ff   <= '0;
         base_ff <= WA_W'(int'(c_ff) * int'(kk_ff));
      end else if (cmd.oc_next) begin
         oc_ff   <= oc_ff + OC_W'(1);
         base_ff <= base_ff + ninkk_ff;
      end
      if (cmd.k_init) begin
         kr_ff   <= '0;
         kc_ff   <= '0;
         wa_ff   <= base_ff;
         rrow_ff <= rrow_init;
         rcol_ff <= left;
      end else if (cmd.issue) begin
         wa_ff <= wa_ff + WA_W'(1);
         if (int'(kc_ff) + 1 >= int'(k_ff)) begin
            kc_ff   <= '0;
            kr_ff   <= kr_ff + 3'd1;
            rcol_ff <= left;
            rrow_ff <= (int'(rrow_ff) + 1 >= MAX_KERNEL) ? '0 : rrow_ff + KR_W'(1);
         end else begin
            kc_ff   <= kc_ff + 3'd1;
            rcol_ff <= rcol_ff + COL_W'(1);
         end
      end
   end

   // weight store
   always_ff @(posedge clock) begin
      if (cmd.wt_write && ({20'b0, req_weight_index} < WDEPTH)) begin
         wmem[WI_W'(req_weight_index)] <= req_weight_value;
      end
      if (cmd.issue) begin
         wq_ff <= wmem[WI_W'(wa_ff)];
         wz_ff <= !(int'(wa_ff) < WDEPTH);
      end
   end

   // row buffers
   always_ff @(posedge clock) begin
      if (cmd.px_write) begin
         rbuf[RI_W'(int'(rmod_ff) * MAX_WIDTH + int'(col_ff))] <= req_pixel_value;
      end
      if (cmd.issue) begin
         pq_ff <= rbuf[RI_W'(int'(rrow_ff) * MAX_WIDTH + int'(rcol_ff))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= wz_ff ? '0 : PROD_W'(pq_ff * wq_ff);
      if (cmd.k_init) acc_ff <= '0;
      else if (v2_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
   end

   // partial sums
   assign pa = PI_W'(int'(oc_ff) * (MAX_HEIGHT * MAX_WIDTH) + int'(top) * MAX_WIDTH + int'(left));

   always_comb begin
      tot = TOT_W'(acc_ff);
      if (c_ff != '0) tot = tot + TOT_W'(psq_ff);
      if (tot > SMAX) sat = cnv2d_pkg::SUM_W'(SMAX);
      else if (tot < SMIN) sat = cnv2d_pkg::SUM_W'(SMIN);
      else sat = cnv2d_pkg::SUM_W'(tot);
   end

   always_ff @(posedge clock) begin
      if (cmd.psum_rd) psq_ff <= pmem[pa];
      if (cmd.psum_wr) pmem[pa] <= sat;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.psum_wr && status.last_ch) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.psum_wr && status.last_ch) begin
         rsp_out_channel <= 4'(oc_ff);
         rsp_out_row     <= 5'(top);
         rsp_out_col     <= 5'(left);
         rsp_conv_sum    <= sat;
         rsp_last        <= status.oc_last;
         rsp_image_done  <= status.oc_last && row_end && col_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ===== hdl/conv2d_valid_multichannel.sv =====
// Top level of the multichannel valid-mode 2D convolution block.
// A weight item is stored at once. A pixel item is written, then checked for a completed window.
// A pixel item completing a window then walks every output channel for kernel side k: kernel
// init, k*k taps on the single multiply-accumulate unit fed one weight and one pixel a cycle,
// drain, partial-sum read and write; on the last input channel each sum also waits while the
// output register is stalled. One item in flight at a time. Reset (synchronous, active high)
// restores register defaults and zeroes the pixel position counters.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_valid_multichannel #(
   parameter int IN_CHANNELS  = cnv2d_pkg::IN_CHANNELS_DEF,
   parameter int OUT_CHANNELS = cnv2d_pkg::OUT_CHANNELS_DEF,
   parameter int MAX_KERNEL   = cnv2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH    = cnv2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = cnv2d_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration writes, to be given only while idle; the block itself does not enforce this
   input  wire logic                               csr_write_en,
   input  wire logic [cnv2d_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cnv2d_pkg::CSR_DATA_W-1:0]   csr_data,
   // input items: weights or pixels
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_action,
   input  wire logic [11:0]                        req_weight_index,
   input  wire logic signed [cnv2d_pkg::WT_W-1:0]  req_weight_value,
   input  wire logic signed [cnv2d_pkg::PIX_W-1:0] req_pixel_value,
   // result items: one sum per output channel per window
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [3:0]                              rsp_out_channel,
   output logic [4:0]                              rsp_out_row,
   output logic [4:0]                              rsp_out_col,
   output logic signed [cnv2d_pkg::SUM_W-1:0]      rsp_conv_sum,
   output logic                                    rsp_last,
   output logic                                    rsp_image_done
);
   cnv2d_pkg::cmd_type    cmd;
   cnv2d_pkg::status_type status;

   // sequencer: accepts items, walks output channels and kernel taps
   cnv2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .status     (status)
   );

   // stores, counters, MAC and the output register; the output register lets
   // the next item in while the final sum waits
   cnv2d_dp #(
      .IN_CHANNELS  (IN_CHANNELS),
      .OUT_CHANNELS (OUT_CHANNELS),
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_pixel_value  (req_pixel_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_conv_sum     (rsp_conv_sum),
      .rsp_last         (rsp_last),
      .rsp_image_done   (rsp_image_done)
   );
endmodule
`default_nettype wire
